/* src/dcta_pkg.sv */
package dcta_pkg;

	localparam int unsigned REF_COUNTS_W = 15;
	localparam int unsigned SLOPE_W      = 16;
	localparam int unsigned TEMP_W       = 16;
	localparam int unsigned SUM_W        = 16;
	localparam int unsigned CFG_W        = 16;
	localparam int unsigned CFG_IDX_W    = 3;

	// counts to temperature scaling, as shift amounts (4096 and 64)
	localparam int unsigned EXT_SHIFT = 12;
	localparam int unsigned INT_SHIFT = 6;

	// difference of a 16-bit sum and a 15-bit reference, signed
	localparam int unsigned DIFF_W = SUM_W + 1;
	localparam int unsigned PROD_W = DIFF_W + SLOPE_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EXT_REF_COUNTS = 3'd0,
		REG_EXT_SLOPE      = 3'd1,
		REG_EXT_REF_TEMP   = 3'd2,
		REG_INT_REF_COUNTS = 3'd3,
		REG_INT_SLOPE      = 3'd4,
		REG_INT_REF_TEMP   = 3'd5
	} reg_idx_t;

	typedef enum logic {
		ACT_SAMPLE = 1'b0,
		ACT_FETCH  = 1'b1
	} action_t;

	typedef enum logic {
		CHAN_EXT = 1'b0,
		CHAN_INT = 1'b1
	} chan_t;

endpackage

/* src/dual_channel_temp_accumulator_top.sv */
// Two-channel temperature accumulator with linear calibration.
// Input channel (in_valid / in_stall): each word is either a converter sample
// (action low) for the channel shown on next_channel, or a fetch request
// (action high). Samples alternate external, internal; after every
// PAIRS_PER_GROUP pairs both sums are latched and marked ready if the previous
// group was fetched. A fetch of a ready group converts it to temperatures.
// Output channel (out_valid / out_stall): exactly one result word per input
// word, in order: fetched, ext_temp, int_temp, next_channel.
// Words pass the input register, then the result register. Throughput is one
// word per cycle without stalls; the path between the registers holds the sum
// update and one 17x16 multiply per channel with its rounding and offset add.
// A stalled result holds; the input register still takes a word behind it,
// and in_stall rises only when both registers are full and out_stall is high.
// Configuration is a plain write port (wr_en, wr_index, wr_data), which the user
// writes only while no word is in flight, unchecked by the block. Reset clears
// sums, counters, the ready flag, both temperatures, config and both valid bits.
module dual_channel_temp_accumulator_top
	import dcta_pkg::*;
#(
	parameter int unsigned PAIRS_PER_GROUP = 16,
	parameter int unsigned SAMPLE_BITS     = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,

	input  logic                   wr_en,
	input  logic [CFG_IDX_W-1:0]   wr_index,
	input  logic [CFG_W-1:0]       wr_data,

	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   action,
	input  logic [SAMPLE_BITS-1:0] sample,

	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   fetched,
	output logic [TEMP_W-1:0]      ext_temp,
	output logic [TEMP_W-1:0]      int_temp,
	output logic                   next_channel
);

	localparam int unsigned CNT_W = $clog2(PAIRS_PER_GROUP);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PAIRS_PER_GROUP - 1);

	// configuration registers
	logic [REF_COUNTS_W-1:0] ext_ref_counts_q, int_ref_counts_q;
	logic [SLOPE_W-1:0]      ext_slope_q, int_slope_q;
	logic [TEMP_W-1:0]       ext_ref_temp_q, int_ref_temp_q;

	// accumulator state
	logic [SUM_W-1:0]  sum_ext_q, sum_int_q;
	logic [SUM_W-1:0]  latched_ext_q, latched_int_q;
	logic              chan_q;
	logic [CNT_W-1:0]  pair_cnt_q;
	logic              ready_q;
	logic [TEMP_W-1:0] temp_ext_q, temp_int_q;

	// input register
	logic                   valid_s1;
	logic                   action_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;

	logic in_take, s1_move;

	assign s1_move  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !s1_move;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			action_s1 <= action;
			sample_s1 <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_ref_counts_q <= '0;
			ext_slope_q      <= '0;
			ext_ref_temp_q   <= '0;
			int_ref_counts_q <= '0;
			int_slope_q      <= '0;
			int_ref_temp_q   <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_EXT_REF_COUNTS: ext_ref_counts_q <= wr_data[REF_COUNTS_W-1:0];
				REG_EXT_SLOPE:      ext_slope_q      <= wr_data[SLOPE_W-1:0];
				REG_EXT_REF_TEMP:   ext_ref_temp_q   <= wr_data[TEMP_W-1:0];
				REG_INT_REF_COUNTS: int_ref_counts_q <= wr_data[REF_COUNTS_W-1:0];
				REG_INT_SLOPE:      int_slope_q      <= wr_data[SLOPE_W-1:0];
				REG_INT_REF_TEMP:   int_ref_temp_q   <= wr_data[TEMP_W-1:0];
				default: ;
			endcase
		end
	end

	// calibration, quotient truncated toward zero by biasing negatives
	logic signed [DIFF_W-1:0] diff_ext, diff_int;
	logic signed [PROD_W-1:0] prod_ext, prod_int, biased_ext, biased_int;
	logic [TEMP_W-1:0]        conv_ext, conv_int;

	always_comb begin
		diff_ext   = $signed({2'b00, ext_ref_counts_q}) - $signed({1'b0, latched_ext_q});
		diff_int   = $signed({1'b0, latched_int_q}) - $signed({2'b00, int_ref_counts_q});
		prod_ext   = diff_ext * $signed(ext_slope_q);
		prod_int   = diff_int * $signed(int_slope_q);
		biased_ext = prod_ext
			+ $signed({{(PROD_W-EXT_SHIFT){1'b0}}, {EXT_SHIFT{prod_ext[PROD_W-1]}}});
		biased_int = prod_int
			+ $signed({{(PROD_W-INT_SHIFT){1'b0}}, {INT_SHIFT{prod_int[PROD_W-1]}}});
		conv_ext   = biased_ext[EXT_SHIFT +: TEMP_W] + ext_ref_temp_q;
		conv_int   = biased_int[INT_SHIFT +: TEMP_W] + int_ref_temp_q;
	end

	// next state for one word
	logic [SUM_W-1:0]  sample_ext;
	logic [SUM_W-1:0]  sum_ext_d, sum_int_d, latched_ext_d, latched_int_d;
	logic              chan_d, ready_d, fetched_d;
	logic [CNT_W-1:0]  pair_cnt_d;
	logic [TEMP_W-1:0] temp_ext_d, temp_int_d;

	always_comb begin
		sample_ext    = SUM_W'(sample_s1);
		sum_ext_d     = sum_ext_q;
		sum_int_d     = sum_int_q;
		latched_ext_d = latched_ext_q;
		latched_int_d = latched_int_q;
		chan_d        = chan_q;
		ready_d       = ready_q;
		pair_cnt_d    = pair_cnt_q;
		temp_ext_d    = temp_ext_q;
		temp_int_d    = temp_int_q;
		fetched_d     = 1'b0;
		if (action_s1 == ACT_SAMPLE) begin
			chan_d = ~chan_q;
			if (chan_q == CHAN_EXT) begin
				sum_ext_d = sum_ext_q + sample_ext;
			end else begin
				sum_int_d  = sum_int_q + sample_ext;
				pair_cnt_d = (pair_cnt_q == CNT_LAST) ? '0 : pair_cnt_q + 1'b1;
				// group complete and the previous one was consumed
				if (pair_cnt_q == CNT_LAST && !ready_q) begin
					latched_ext_d = sum_ext_q;
					latched_int_d = sum_int_d;
					sum_ext_d     = '0;
					sum_int_d     = '0;
					ready_d       = 1'b1;
				end
			end
		end else if (ready_q) begin
			ready_d    = 1'b0;
			temp_ext_d = conv_ext;
			temp_int_d = conv_int;
			fetched_d  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_ext_q     <= '0;
			sum_int_q     <= '0;
			latched_ext_q <= '0;
			latched_int_q <= '0;
			chan_q        <= CHAN_EXT;
			pair_cnt_q    <= '0;
			ready_q       <= 1'b0;
			temp_ext_q    <= '0;
			temp_int_q    <= '0;
		end else if (s1_move) begin
			sum_ext_q     <= sum_ext_d;
			sum_int_q     <= sum_int_d;
			latched_ext_q <= latched_ext_d;
			latched_int_q <= latched_int_d;
			chan_q        <= chan_d;
			pair_cnt_q    <= pair_cnt_d;
			ready_q       <= ready_d;
			temp_ext_q    <= temp_ext_d;
			temp_int_q    <= temp_int_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (s1_move) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			fetched      <= fetched_d;
			ext_temp     <= temp_ext_d;
			int_temp     <= temp_int_d;
			next_channel <= chan_d;
		end
	end

endmodule

/* test/temp_checker.sv */
`timescale 1ns / 100ps

module temp_checker
	import dcta_pkg::*;
#(
	parameter int unsigned PAIRS_PER_GROUP = 16,
	parameter int unsigned SAMPLE_BITS     = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,

	input  logic                   wr_en,
	input  logic [CFG_IDX_W-1:0]   wr_index,
	input  logic [CFG_W-1:0]       wr_data,

	input  logic                   in_valid,
	input  logic                   in_stall,
	input  logic                   action,
	input  logic [SAMPLE_BITS-1:0] sample,

	input  logic                   out_valid,
	input  logic                   out_stall,
	input  logic                   fetched,
	input  logic [TEMP_W-1:0]      ext_temp,
	input  logic [TEMP_W-1:0]      int_temp,
	input  logic                   next_channel,

	output int                     errors,
	output int                     outstanding,
	output int                     fresh_fetches,
	output int                     words_checked
);

	localparam longint EXT_SCALE  = 4096;
	localparam longint INT_SCALE  = 64;
	localparam int     MAX_REPORT = 10;

	typedef struct packed {
		logic              fetched;
		logic [TEMP_W-1:0] ext_temp;
		logic [TEMP_W-1:0] int_temp;
		logic              next_channel;
	} temp_word_t;

	// calibration copy
	logic [REF_COUNTS_W-1:0]  ext_counts_cfg, int_counts_cfg;
	logic signed [SLOPE_W-1:0] ext_slope_cfg, int_slope_cfg;
	logic [TEMP_W-1:0]        ext_offset_cfg, int_offset_cfg;

	// accumulator state
	logic [SUM_W-1:0]  ext_acc, int_acc, grp_ext, grp_int;
	chan_t             chan;
	int unsigned       pair_cnt;
	logic              grp_ready;
	logic [TEMP_W-1:0] ext_temp_q, int_temp_q;

	temp_word_t pending_temps[$];
	int         err_cnt, hit_cnt, seen_cnt;

	function automatic logic [TEMP_W-1:0] convert_counts(input longint diff, input longint slope,
			input longint scale, input longint offset);
		longint quot;
		// signed division truncates toward zero
		quot = (diff * slope) / scale;
		return TEMP_W'(quot + offset);
	endfunction

	task automatic predict_word(input action_t act, input logic [SAMPLE_BITS-1:0] smp,
			output temp_word_t w);
		w.fetched = 1'b0;
		if (act == ACT_SAMPLE) begin
			if (chan == CHAN_EXT)
				ext_acc = ext_acc + SUM_W'(smp);
			else
				int_acc = int_acc + SUM_W'(smp);
			chan = (chan == CHAN_EXT) ? CHAN_INT : CHAN_EXT;
			if (chan == CHAN_EXT) begin
				pair_cnt = (pair_cnt + 1) % PAIRS_PER_GROUP;
				// an unread group blocks the latch, sums keep growing
				if (pair_cnt == 0 && !grp_ready) begin
					grp_ext   = ext_acc;
					grp_int   = int_acc;
					ext_acc   = '0;
					int_acc   = '0;
					grp_ready = 1'b1;
				end
			end
		end else if (grp_ready) begin
			grp_ready  = 1'b0;
			ext_temp_q = convert_counts(longint'(ext_counts_cfg) - longint'(grp_ext),
				longint'(ext_slope_cfg), EXT_SCALE, longint'(ext_offset_cfg));
			int_temp_q = convert_counts(longint'(grp_int) - longint'(int_counts_cfg),
				longint'(int_slope_cfg), INT_SCALE, longint'(int_offset_cfg));
			w.fetched  = 1'b1;
		end
		w.ext_temp     = ext_temp_q;
		w.int_temp     = int_temp_q;
		w.next_channel = chan;
	endtask

	always @(posedge clk or negedge arst_n) begin
		temp_word_t want, got;
		if (!arst_n) begin
			ext_counts_cfg = '0;
			int_counts_cfg = '0;
			ext_slope_cfg  = '0;
			int_slope_cfg  = '0;
			ext_offset_cfg = '0;
			int_offset_cfg = '0;
			ext_acc        = '0;
			int_acc        = '0;
			grp_ext        = '0;
			grp_int        = '0;
			chan           = CHAN_EXT;
			pair_cnt       = 0;
			grp_ready      = 1'b0;
			ext_temp_q     = '0;
			int_temp_q     = '0;
			pending_temps.delete();
			err_cnt        = 0;
			hit_cnt        = 0;
			seen_cnt       = 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_EXT_REF_COUNTS: ext_counts_cfg = wr_data[REF_COUNTS_W-1:0];
					REG_EXT_SLOPE:      ext_slope_cfg  = wr_data[SLOPE_W-1:0];
					REG_EXT_REF_TEMP:   ext_offset_cfg = wr_data[TEMP_W-1:0];
					REG_INT_REF_COUNTS: int_counts_cfg = wr_data[REF_COUNTS_W-1:0];
					REG_INT_SLOPE:      int_slope_cfg  = wr_data[SLOPE_W-1:0];
					REG_INT_REF_TEMP:   int_offset_cfg = wr_data[TEMP_W-1:0];
					default: ;
				endcase
			end

			if (out_valid && !out_stall) begin
				got = '{fetched, ext_temp, int_temp, next_channel};
				seen_cnt++;
				if (pending_temps.size() == 0) begin
					err_cnt++;
					if (err_cnt <= MAX_REPORT)
						$display("%0t: result word with nothing expected: %h", $realtime, got);
				end else begin
					want = pending_temps.pop_front();
					if (want.fetched)
						hit_cnt++;
					if (got.fetched !== want.fetched || got.ext_temp !== want.ext_temp ||
							got.int_temp !== want.int_temp ||
							got.next_channel !== want.next_channel) begin
						err_cnt++;
						if (err_cnt <= MAX_REPORT)
							$display("%0t: word %0d expected fetched=%b ext=%h int=%h chan=%b, got fetched=%b ext=%h int=%h chan=%b",
								$realtime, seen_cnt, want.fetched, want.ext_temp,
								want.int_temp, want.next_channel, got.fetched,
								got.ext_temp, got.int_temp, got.next_channel);
					end
				end
			end

			if (in_valid && !in_stall) begin
				predict_word(action_t'(action), sample, want);
				pending_temps.push_back(want);
			end
		end
		errors        <= err_cnt;
		outstanding   <= pending_temps.size();
		fresh_fetches <= hit_cnt;
		words_checked <= seen_cnt;
	end

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench;
	import dcta_pkg::*;

	localparam int unsigned PAIRS_PER_GROUP  = 16;
	localparam int unsigned SAMPLE_BITS      = 10;
	localparam int          CYCLE_LIMIT      = 300000;
	localparam int          RANDOM_PER_PHASE = 330;
	localparam int          HOLD_CYCLES      = 400;
	localparam int          FETCH_PCT [4]    = '{0, 2, 6, 35};
	// indexes past the last register, the block ignores them
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   wr_en;
	logic [CFG_IDX_W-1:0]   wr_index;
	logic [CFG_W-1:0]       wr_data;
	logic                   in_valid;
	logic                   in_stall;
	logic                   action;
	logic [SAMPLE_BITS-1:0] sample;
	logic                   out_valid;
	logic                   out_stall;
	logic                   fetched;
	logic [TEMP_W-1:0]      ext_temp;
	logic [TEMP_W-1:0]      int_temp;
	logic                   next_channel;

	int errors, outstanding, fresh_fetches, words_checked;
	int cycles = 0;
	int settings;
	bit sender_eager;

	dual_channel_temp_accumulator_top #(
		.PAIRS_PER_GROUP(PAIRS_PER_GROUP),
		.SAMPLE_BITS    (SAMPLE_BITS)
	) dut (
		.clk, .arst_n, .wr_en, .wr_index, .wr_data,
		.in_valid, .in_stall, .action, .sample,
		.out_valid, .out_stall, .fetched, .ext_temp, .int_temp, .next_channel
	);

	temp_checker #(
		.PAIRS_PER_GROUP(PAIRS_PER_GROUP),
		.SAMPLE_BITS    (SAMPLE_BITS)
	) temp_check (
		.clk, .arst_n, .wr_en, .wr_index, .wr_data,
		.in_valid, .in_stall, .action, .sample,
		.out_valid, .out_stall, .fetched, .ext_temp, .int_temp, .next_channel,
		.errors, .outstanding, .fresh_fetches, .words_checked
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still expected", cycles, outstanding);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic send_word(input action_t act, input logic [SAMPLE_BITS-1:0] smp);
		int gap;
		gap = sender_eager ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action   <= act;
		sample   <= smp;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
	endtask

	task automatic program_regs(input logic [CFG_W-1:0] ext_counts, ext_slope, ext_offset,
			int_counts, int_slope, int_offset);
		write_reg(REG_EXT_REF_COUNTS, ext_counts);
		write_reg(REG_EXT_SLOPE, ext_slope);
		write_reg(REG_EXT_REF_TEMP, ext_offset);
		write_reg(REG_INT_REF_COUNTS, int_counts);
		write_reg(REG_INT_SLOPE, int_slope);
		write_reg(REG_INT_REF_TEMP, int_offset);
		write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, CFG_W'($urandom));
		wr_en <= 1'b0;
		@(posedge clk);
		settings++;
	endtask

	// wait until every word in flight has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_random(input int count);
		int left, seg, pct, i;
		bit high_bias;
		logic [SAMPLE_BITS-1:0] smp;
		left = count;
		while (left > 0) begin
			seg = $urandom_range(20, 80);
			if (seg > left)
				seg = left;
			// zero fetch rate leaves a group unread while the sums keep growing and wrap
			pct          = FETCH_PCT[$urandom_range(0, 3)];
			high_bias    = ($urandom_range(0, 3) == 0);
			sender_eager = ($urandom_range(0, 3) == 0);
			for (i = 0; i < seg; i++) begin
				if ($urandom_range(0, 99) < pct) begin
					send_word(ACT_FETCH, SAMPLE_BITS'($urandom));
				end else begin
					smp = high_bias ? ~SAMPLE_BITS'($urandom_range(0, 15)) : SAMPLE_BITS'($urandom);
					send_word(ACT_SAMPLE, smp);
				end
			end
			left -= seg;
		end
	endtask

	// receiver: random stall per word, long hold-offs to back the block up
	initial begin
		int gap, taken;
		bit eager;
		out_stall = 1'b1;
		taken     = 0;
		eager     = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 49) == 0)
				eager = !eager;
			if (taken == 300 || taken == 1300)
				gap = HOLD_CYCLES;
			else
				gap = eager ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
			taken++;
		end
	end

	initial begin
		arst_n       = 1'b0;
		wr_en        = 1'b0;
		wr_index     = '0;
		wr_data      = '0;
		in_valid     = 1'b0;
		action       = ACT_SAMPLE;
		sample       = '0;
		settings     = 0;
		sender_eager = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: fetch with nothing ready, sample extremes, odd bit patterns
		send_word(ACT_FETCH, '0);
		send_word(ACT_SAMPLE, '0);
		send_word(ACT_SAMPLE, '1);
		send_word(ACT_FETCH, '1);
		send_word(ACT_SAMPLE, 10'h155);
		send_word(ACT_SAMPLE, 10'h2aa);
		send_word(ACT_SAMPLE, 10'h001);
		send_word(ACT_FETCH, 10'h155);
		send_word(ACT_SAMPLE, 10'h200);
		send_word(ACT_SAMPLE, '1);
		send_word(ACT_SAMPLE, '1);
		send_word(ACT_SAMPLE, '0);
		send_word(ACT_FETCH, 10'h2aa);
		send_word(ACT_FETCH, '0);
		send_word(ACT_SAMPLE, '1);
		send_word(ACT_SAMPLE, 10'h3fe);
		run_random(RANDOM_PER_PHASE);
		drain();

		program_regs(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
			CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
		run_random(RANDOM_PER_PHASE);
		drain();

		// largest counts, slope and offset
		program_regs(16'hffff, 16'h7fff, 16'hffff, 16'hffff, 16'h7fff, 16'hffff);
		run_random(RANDOM_PER_PHASE);
		drain();

		// most negative slope, zero counts and offset
		program_regs(16'h0000, 16'h8000, 16'h0000, 16'h0000, 16'h8000, 16'h0000);
		run_random(RANDOM_PER_PHASE);
		drain();

		// counts near a typical group sum
		program_regs(CFG_W'($urandom_range(0, 20000)), CFG_W'($urandom), CFG_W'($urandom),
			CFG_W'($urandom_range(0, 20000)), CFG_W'($urandom), CFG_W'($urandom));
		run_random(RANDOM_PER_PHASE);
		drain();

		program_regs(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
			CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
		run_random(RANDOM_PER_PHASE);
		drain();
		repeat (8) @(posedge clk);

		$display("checked %0d result words over %0d calibration settings plus reset values",
			words_checked, settings);
		$display("%0d fetches converted a fresh group, %0d mismatching words", fresh_fetches,
			errors);
		if (errors == 0 && outstanding == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
